FILE: rtl/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// Serial bank-switch mapper package
// Types, register codes and widths shared by the mapper's modules.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Bank sizes in bits
  localparam int PRG_BANK_BITS = 4;
  localparam int CHR_BANK_BITS = 5;
  localparam int REG_BITS      = 5;

  // Stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_VARIANT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRAM_SIZE    = 1'b1;

  // Bank register select codes, taken from address bits 14:13
  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_CHR0    = 2'd1;
  localparam logic [1:0] REG_CHR1    = 2'd2;
  localparam logic [1:0] REG_PRG     = 2'd3;

  // PRG banking modes, control bits 3:2
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // Work RAM size codes
  localparam logic [1:0] WRAM_NONE = 2'd0;
  localparam logic [1:0] WRAM_8K   = 2'd1;
  localparam logic [1:0] WRAM_16K  = 2'd2;
  localparam logic [1:0] WRAM_32K  = 2'd3;

  // Chip revisions
  localparam logic CHIP_REV_A = 1'b0;
  localparam logic CHIP_REV_B = 1'b1;

  // Serial port constants
  localparam logic [REG_BITS-1:0] CONTROL_RESET = 5'h0C;
  localparam logic [2:0]          SHIFT_LAST    = 3'd4;
  localparam logic [1:0]          BUSY_CYCLES   = 2'd2;

  // One CPU write
  typedef struct packed {
    logic [7:0]  cycles_elapsed;
    logic [7:0]  data;
    logic [15:0] cpu_addr;
  } in_item_t;

  // The four bank registers
  typedef struct packed {
    logic [REG_BITS-1:0] prg;
    logic [REG_BITS-1:0] chr1;
    logic [REG_BITS-1:0] chr0;
    logic [REG_BITS-1:0] control;
  } bank_regs_t;

  // Configuration seen by the mapping logic
  typedef struct packed {
    logic       chip_variant;
    logic [1:0] wram_size_code;
  } cfg_t;

  // One bank mapping result
  typedef struct packed {
    logic [1:0]               wram_bank;
    logic                     wram_enable;
    logic [1:0]               mirroring;
    logic [CHR_BANK_BITS-1:0] chr_bank_high;
    logic [CHR_BANK_BITS-1:0] chr_bank_low;
    logic [PRG_BANK_BITS-1:0] prg_bank_high;
    logic [PRG_BANK_BITS-1:0] prg_bank_low;
  } map_result_t;

endpackage

FILE: rtl/sbsm_serial.sv
// ----------------------------------------------------------------------------
// Serial port and bank registers
// Holds the busy counter, the 5-bit shifter and the four bank registers, and
// gives the register values that follow the write being processed.
// ----------------------------------------------------------------------------
module sbsm_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  sbsm_pkg::in_item_t item,
  output sbsm_pkg::bank_regs_t banks_nxt
);
  import sbsm_pkg::*;

  bank_regs_t          banks_r;
  logic [REG_BITS-1:0] shift_r, shift_nxt, shift_fill;
  logic [2:0]          count_r, count_nxt;
  logic [1:0]          since_r, since_nxt;
  logic [8:0]          since_sum;
  logic [1:0]          since_sat;
  logic [REG_BITS-1:0] serial_bit;

  // Saturating count of cycles since the last reset write
  assign since_sum  = {7'd0, since_r} + {1'b0, item.cycles_elapsed};
  assign since_sat  = (since_sum >= {7'd0, BUSY_CYCLES}) ? BUSY_CYCLES : since_sum[1:0];
  assign serial_bit = {{(REG_BITS-1){1'b0}}, item.data[0]};
  assign shift_fill = shift_r | (serial_bit << count_r);

  // Next state for one write
  always_comb begin
    banks_nxt = banks_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    since_nxt = since_r;
    if (fire) begin
      since_nxt = since_sat;
      if (since_sat >= BUSY_CYCLES) begin
        if (item.data[7]) begin
          banks_nxt.control = banks_r.control | CONTROL_RESET;
          shift_nxt = '0;
          count_nxt = '0;
          since_nxt = '0;
        end else if (count_r >= SHIFT_LAST) begin
          // Fifth bit: load the target register
          shift_nxt = '0;
          count_nxt = '0;
          case (item.cpu_addr[14:13])
            REG_CONTROL: banks_nxt.control = shift_fill;
            REG_CHR0:    banks_nxt.chr0    = shift_fill;
            REG_CHR1:    banks_nxt.chr1    = shift_fill;
            REG_PRG:     banks_nxt.prg     = shift_fill;
            default:     banks_nxt.prg     = shift_fill;
          endcase
        end else begin
          shift_nxt = shift_fill;
          count_nxt = count_r + 3'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r <= '{prg: '0, chr1: '0, chr0: '0, control: CONTROL_RESET};
      shift_r <= '0;
      count_r <= '0;
      since_r <= '0;
    end else begin
      banks_r <= banks_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      since_r <= since_nxt;
    end
  end

endmodule

FILE: rtl/sbsm_map.sv
// ----------------------------------------------------------------------------
// Bank mapping decode
// Turns the bank registers and the configuration into PRG, CHR, mirroring and
// work RAM selections.
// ----------------------------------------------------------------------------
module sbsm_map (
  input  sbsm_pkg::bank_regs_t  banks,
  input  sbsm_pkg::cfg_t        cfg,
  output sbsm_pkg::map_result_t result
);
  import sbsm_pkg::*;

  logic [PRG_BANK_BITS-1:0] prg_low, prg_high;
  logic                     prg_high_rule;

  // PRG banks by mode
  always_comb begin
    case (banks.control[3:2])
      PRG_MODE_FIX_LAST: begin
        prg_low  = banks.prg[3:0];
        prg_high = 4'hF;
      end
      PRG_MODE_FIX_FIRST: begin
        prg_low  = '0;
        prg_high = banks.prg[3:0];
      end
      default: begin
        prg_low  = {banks.prg[3:1], 1'b0};
        prg_high = {banks.prg[3:1], 1'b1};
      end
    endcase
  end

  // On revision A, PRG bit 4 keeps the bank's top bit from the register
  assign prg_high_rule = banks.prg[4] && (cfg.chip_variant == CHIP_REV_A);

  always_comb begin
    result.prg_bank_low  = prg_high_rule ? {banks.prg[3], prg_low[2:0]} : prg_low;
    result.prg_bank_high = prg_high_rule ? {banks.prg[3], prg_high[2:0]} : prg_high;

    // CHR banks: 4K mode uses both registers, 8K mode pairs CHR 0
    if (banks.control[4]) begin
      result.chr_bank_low  = banks.chr0;
      result.chr_bank_high = banks.chr1;
    end else begin
      result.chr_bank_low  = {banks.chr0[4:1], 1'b0};
      result.chr_bank_high = {banks.chr0[4:1], 1'b1};
    end

    result.mirroring = banks.control[1:0];

    // Work RAM presence and bank
    result.wram_enable = (cfg.wram_size_code != WRAM_NONE) &&
                         !(banks.prg[4] && (cfg.chip_variant == CHIP_REV_B));
    case (cfg.wram_size_code)
      WRAM_32K: result.wram_bank = banks.chr0[3:2];
      WRAM_16K: result.wram_bank = {1'b0, banks.chr0[3]};
      default:  result.wram_bank = 2'd0;
    endcase
  end

endmodule

FILE: rtl/serial_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// Serial bank-switch mapper
// Each input transaction is one CPU write above 0x8000; each gives exactly one
// output transaction carrying the bank mapping after that write. A write is
// registered on entry, then the serial port update and the mapping decode run
// combinationally into the output register, so one transaction is taken per
// clock unless out_tready stalls; the output register lets a new write enter
// while a result still waits. Configuration takes effect on the next result.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: cpu_addr[15:0], data[23:16], cycles_elapsed[31:24]
  input  logic [sbsm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: prg_bank_low[3:0], prg_bank_high[7:4], chr_bank_low[12:8],
  //        chr_bank_high[17:13], mirroring[19:18], wram_enable[20],
  //        wram_bank[22:21], zero[23]
  output logic [sbsm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [sbsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sbsm_pkg::*;

  in_item_t    item_r;
  logic        item_valid_r;
  logic        fire;
  cfg_t        cfg_r;
  bank_regs_t  banks_nxt;
  map_result_t result;
  map_result_t result_r;
  logic        out_valid_r;

  // Process the held write when the output register is free or draining
  assign fire      = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item_t'(in_tdata);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{chip_variant: CHIP_REV_B, wram_size_code: WRAM_8K};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHIP_VARIANT: cfg_r.chip_variant   <= cfg_wdata[0];
        CFG_WRAM_SIZE:    cfg_r.wram_size_code <= cfg_wdata[1:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // Serial port state
  sbsm_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .banks_nxt (banks_nxt)
  );

  // Mapping decode
  sbsm_map u_map (
    .banks  (banks_nxt),
    .cfg    (cfg_r),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, result_r};

endmodule
